// File: rtl/core/sbct_pkg.sv
// Shared types and constants for the swept box collision time unit.
// Used by sbct_front, sbct_resolve and the top level; depends on nothing.
package sbct_pkg;

    // Per-item control flags that travel alongside the division pipeline.
    typedef struct packed {
        logic early_miss;
        logic zero_x;
        logic zero_y;
        logic dx_pos;
        logic dy_pos;
    } sbct_flags_t;

    // Lane numbering of the four per-axis time divisions.
    localparam int unsigned LANE_X_IN  = 0;
    localparam int unsigned LANE_X_OUT = 1;
    localparam int unsigned LANE_Y_IN  = 2;
    localparam int unsigned LANE_Y_OUT = 3;
    localparam int unsigned NUM_LANES  = 4;

    // Contact normal codes.
    localparam logic signed [1:0] NORM_NEG  = -2'sd1;
    localparam logic signed [1:0] NORM_ZERO = 2'sd0;
    localparam logic signed [1:0] NORM_POS  = 2'sd1;

endpackage

// File: rtl/core/sbct_front.sv
// Front stage: swept-box overlap test and divider operand set-up.
// Depends on sbct_pkg.
module sbct_front #(
    parameter int unsigned W = 24
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [W-1:0]                    move_left,
    input  logic signed [W-1:0]                    move_top,
    input  logic signed [W-1:0]                    move_right,
    input  logic signed [W-1:0]                    move_bottom,
    input  logic signed [W-1:0]                    disp_x,
    input  logic signed [W-1:0]                    disp_y,
    input  logic signed [W-1:0]                    fixed_left,
    input  logic signed [W-1:0]                    fixed_top,
    input  logic signed [W-1:0]                    fixed_right,
    input  logic signed [W-1:0]                    fixed_bottom,
    output sbct_pkg::sbct_flags_t                  flags_o,
    output logic [sbct_pkg::NUM_LANES-1:0][W:0]    mag_o,
    output logic [sbct_pkg::NUM_LANES-1:0][W-1:0]  den_o,
    output logic [sbct_pkg::NUM_LANES-1:0]         neg_o,
    output logic [sbct_pkg::NUM_LANES-1:0]         ovf_o
);

    logic signed [W:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
    logic signed [W:0] bl, bt, br, bb;
    logic              dx_pos, dy_pos, dx_neg, dy_neg, zero_x, zero_y;
    logic [W-1:0]      dmag_x, dmag_y;
    logic signed [W:0] gap     [sbct_pkg::NUM_LANES];
    logic [W:0]        gap_mag [sbct_pkg::NUM_LANES];
    logic [W-1:0]      den     [sbct_pkg::NUM_LANES];
    logic              dneg    [sbct_pkg::NUM_LANES];

    sbct_pkg::sbct_flags_t                 flags_reg;
    logic [sbct_pkg::NUM_LANES-1:0][W:0]   mag_reg;
    logic [sbct_pkg::NUM_LANES-1:0][W-1:0] den_reg;
    logic [sbct_pkg::NUM_LANES-1:0]        neg_reg, ovf_reg;

    // Sign-extend everything by one bit so sums and differences are exact.
    assign ml = {move_left[W-1], move_left};
    assign mt = {move_top[W-1], move_top};
    assign mr = {move_right[W-1], move_right};
    assign mb = {move_bottom[W-1], move_bottom};
    assign dx = {disp_x[W-1], disp_x};
    assign dy = {disp_y[W-1], disp_y};
    assign sl = {fixed_left[W-1], fixed_left};
    assign st = {fixed_top[W-1], fixed_top};
    assign sr = {fixed_right[W-1], fixed_right};
    assign sb = {fixed_bottom[W-1], fixed_bottom};

    assign zero_x = (disp_x == '0);
    assign zero_y = (disp_y == '0);
    assign dx_neg = disp_x[W-1];
    assign dy_neg = disp_y[W-1];
    assign dx_pos = !dx_neg && !zero_x;
    assign dy_pos = !dy_neg && !zero_y;

    // Box swept by the motion over the frame.
    assign bl = dx_pos ? ml : ml + dx;
    assign br = dx_pos ? mr + dx : mr;
    assign bt = dy_pos ? mt : mt + dy;
    assign bb = dy_pos ? mb + dy : mb;

    // Displacement magnitudes; the most negative value maps to 2^(W-1).
    assign dmag_x = dx_neg ? (~disp_x + 1'b1) : disp_x;
    assign dmag_y = dy_neg ? (~disp_y + 1'b1) : disp_y;

    // Entry and exit distances per axis, chosen by direction of travel.
    always_comb begin
        gap[sbct_pkg::LANE_X_IN]   = dx_pos ? (sl - mr) : (sr - ml);
        gap[sbct_pkg::LANE_X_OUT]  = dx_pos ? (sr - ml) : (sl - mr);
        gap[sbct_pkg::LANE_Y_IN]   = dy_pos ? (st - mb) : (sb - mt);
        gap[sbct_pkg::LANE_Y_OUT]  = dy_pos ? (sb - mt) : (st - mb);
        den[sbct_pkg::LANE_X_IN]   = dmag_x;
        den[sbct_pkg::LANE_X_OUT]  = dmag_x;
        den[sbct_pkg::LANE_Y_IN]   = dmag_y;
        den[sbct_pkg::LANE_Y_OUT]  = dmag_y;
        dneg[sbct_pkg::LANE_X_IN]  = dx_neg;
        dneg[sbct_pkg::LANE_X_OUT] = dx_neg;
        dneg[sbct_pkg::LANE_Y_IN]  = dy_neg;
        dneg[sbct_pkg::LANE_Y_OUT] = dy_neg;
        for (int i = 0; i < sbct_pkg::NUM_LANES; i++) begin
            gap_mag[i] = gap[i][W] ? (~gap[i] + 1'b1) : gap[i];
        end
    end

    // Register flags and per-lane magnitude, sign and overflow.
    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg.early_miss <= (br < sl) || (bl > sr) || (bb < st) || (bt > sb)
                                    || (zero_x && zero_y);
            flags_reg.zero_x     <= zero_x;
            flags_reg.zero_y     <= zero_y;
            flags_reg.dx_pos     <= dx_pos;
            flags_reg.dy_pos     <= dy_pos;
            for (int i = 0; i < sbct_pkg::NUM_LANES; i++) begin
                mag_reg[i] <= gap_mag[i];
                den_reg[i] <= den[i];
                neg_reg[i] <= gap[i][W] ^ dneg[i];
                ovf_reg[i] <= ({1'b0, gap_mag[i]} >= {den[i], 2'b00});
            end
        end
    end

    assign flags_o = flags_reg;
    assign mag_o   = mag_reg;
    assign den_o   = den_reg;
    assign neg_o   = neg_reg;
    assign ovf_o   = ovf_reg;

endmodule

// File: rtl/core/sbct_div.sv
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the top level supplies the stage enables.
module sbct_div #(
    parameter int unsigned W = 24,
    parameter int unsigned F = 16
) (
    input  logic         aclk,
    input  logic [F+1:0] en,
    input  logic [W:0]   mag_i,
    input  logic [W-1:0] den_i,
    input  logic         neg_i,
    input  logic         ovf_i,
    output logic [F+1:0] q_o,
    output logic         remnz_o,
    output logic         neg_o,
    output logic         ovf_o
);

    localparam int unsigned NSTEP = F + 2;

    logic [W:0]   r_reg   [NSTEP];
    logic [W-1:0] d_reg   [NSTEP];
    logic [F+1:0] q_reg   [NSTEP];
    logic         neg_reg [NSTEP];
    logic         ovf_reg [NSTEP];

    // The first step tests twice the divisor, the second the divisor, and
    // every later step doubles the remainder before testing.
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        logic [W:0]   r_prev, r_shift, cmp, r_next;
        logic [W-1:0] d_prev;
        logic [F+1:0] q_prev;
        logic         n_prev, o_prev, q_bit;

        if (s == 0) begin : g_src_in
            assign r_prev = mag_i;
            assign d_prev = den_i;
            assign q_prev = '0;
            assign n_prev = neg_i;
            assign o_prev = ovf_i;
        end else begin : g_src_stage
            assign r_prev = r_reg[s-1];
            assign d_prev = d_reg[s-1];
            assign q_prev = q_reg[s-1];
            assign n_prev = neg_reg[s-1];
            assign o_prev = ovf_reg[s-1];
        end

        if (s >= 2) begin : g_shift
            assign r_shift = {r_prev[W-1:0], 1'b0};
        end else begin : g_noshift
            assign r_shift = r_prev;
        end

        if (s == 0) begin : g_cmp_two
            assign cmp = {d_prev, 1'b0};
        end else begin : g_cmp_one
            assign cmp = {1'b0, d_prev};
        end

        assign q_bit  = (r_shift >= cmp);
        assign r_next = q_bit ? (r_shift - cmp) : r_shift;

        always_ff @(posedge aclk) begin
            if (en[s]) begin
                r_reg[s]   <= r_next;
                d_reg[s]   <= d_prev;
                q_reg[s]   <= {q_prev[F:0], q_bit};
                neg_reg[s] <= n_prev;
                ovf_reg[s] <= o_prev;
            end
        end
    end

    assign q_o     = q_reg[NSTEP-1];
    assign remnz_o = (r_reg[NSTEP-1] != '0);
    assign neg_o   = neg_reg[NSTEP-1];
    assign ovf_o   = ovf_reg[NSTEP-1];

endmodule

// File: rtl/core/sbct_resolve.sv
// Time finishing (floor, saturation) and hit decision with output register.
// Depends on sbct_pkg.
module sbct_resolve #(
    parameter int unsigned F = 16
) (
    input  logic                                  aclk,
    input  logic                                  en_fin,
    input  logic                                  en_out,
    input  sbct_pkg::sbct_flags_t                 flags_i,
    input  logic [sbct_pkg::NUM_LANES-1:0][F+1:0] q_i,
    input  logic [sbct_pkg::NUM_LANES-1:0]        remnz_i,
    input  logic [sbct_pkg::NUM_LANES-1:0]        neg_i,
    input  logic [sbct_pkg::NUM_LANES-1:0]        ovf_i,
    output logic                                  hit_o,
    output logic [F:0]                            time_o,
    output logic signed [1:0]                     normal_x_o,
    output logic signed [1:0]                     normal_y_o
);

    localparam logic signed [F+2:0] T_ONE = {3'b001, {F{1'b0}}};
    localparam logic signed [F+2:0] T_SAT = {3'b010, {F{1'b0}}};
    localparam logic signed [F+2:0] T_UNB = {3'b011, {F{1'b0}}};

    logic signed [F+2:0]   t_next [sbct_pkg::NUM_LANES];
    logic signed [F+2:0]   t_reg  [sbct_pkg::NUM_LANES];
    sbct_pkg::sbct_flags_t flags_reg;

    logic signed [F+2:0] x_in, x_out, y_in, y_out, t_in, t_out;
    logic                hit;
    logic                hit_reg;
    logic [F:0]          time_reg;
    logic signed [1:0]   nx_reg, ny_reg;

    // Floor of the signed quotient, saturated to plus or minus two.
    always_comb begin
        for (int i = 0; i < sbct_pkg::NUM_LANES; i++) begin
            logic [F+2:0] c, m;
            c = {1'b0, q_i[i]} + {{(F+2){1'b0}}, neg_i[i] & remnz_i[i]};
            m = (ovf_i[i] || (c > $unsigned(T_SAT))) ? $unsigned(T_SAT) : c;
            t_next[i] = neg_i[i] ? -$signed(m) : $signed(m);
        end
        // A still axis never bounds the contact time.
        if (flags_i.zero_x) begin
            t_next[sbct_pkg::LANE_X_IN]  = -T_UNB;
            t_next[sbct_pkg::LANE_X_OUT] = T_UNB;
        end
        if (flags_i.zero_y) begin
            t_next[sbct_pkg::LANE_Y_IN]  = -T_UNB;
            t_next[sbct_pkg::LANE_Y_OUT] = T_UNB;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_fin) begin
            t_reg     <= t_next;
            flags_reg <= flags_i;
        end
    end

    // Later entry against earlier exit decides the hit.
    assign x_in  = t_reg[sbct_pkg::LANE_X_IN];
    assign x_out = t_reg[sbct_pkg::LANE_X_OUT];
    assign y_in  = t_reg[sbct_pkg::LANE_Y_IN];
    assign y_out = t_reg[sbct_pkg::LANE_Y_OUT];
    assign t_in  = (x_in > y_in) ? x_in : y_in;
    assign t_out = (x_out < y_out) ? x_out : y_out;
    assign hit   = !flags_reg.early_miss
                   && !((x_in < 0) && (y_in < 0))
                   && !(x_in > T_ONE) && !(y_in > T_ONE)
                   && !(t_in > t_out);

    // Output register; the normal lies on the axis that enters last.
    always_ff @(posedge aclk) begin
        if (en_out) begin
            hit_reg  <= hit;
            time_reg <= hit ? t_in[F:0] : '0;
            nx_reg   <= sbct_pkg::NORM_ZERO;
            ny_reg   <= sbct_pkg::NORM_ZERO;
            if (hit) begin
                if (x_in > y_in) begin
                    nx_reg <= flags_reg.dx_pos ? sbct_pkg::NORM_NEG : sbct_pkg::NORM_POS;
                end else begin
                    ny_reg <= flags_reg.dy_pos ? sbct_pkg::NORM_NEG : sbct_pkg::NORM_POS;
                end
            end
        end
    end

    assign hit_o      = hit_reg;
    assign time_o     = time_reg;
    assign normal_x_o = nx_reg;
    assign normal_y_o = ny_reg;

endmodule

// File: rtl/core/swept_box_collision_time_unit.sv
// Top level of the swept box collision time unit.
// Depends on sbct_pkg, sbct_front, sbct_div and sbct_resolve.

// Takes one moving box, its frame displacement and a static box per request
// and returns one result per request: hit flag, entry time in
// Q1.TIME_FRAC_BITS and the contact normal. The unit is a fully pipelined
// datapath that accepts a request every cycle while the output is not
// stalled; it has TIME_FRAC_BITS + 5 register stages (21 at the defaults).
// The depth is set by the four restoring divider lanes that produce one
// quotient bit per stage, plus a set-up stage before them and a time
// finishing stage and the output register after them. A stalled output
// holds only the stages that are full; empty stages keep filling.
module swept_box_collision_time_unit #(
    parameter int unsigned COORD_WIDTH    = 24,
    parameter int unsigned TIME_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_move_left,
    input  logic signed [COORD_WIDTH-1:0] s_move_top,
    input  logic signed [COORD_WIDTH-1:0] s_move_right,
    input  logic signed [COORD_WIDTH-1:0] s_move_bottom,
    input  logic signed [COORD_WIDTH-1:0] s_disp_x,
    input  logic signed [COORD_WIDTH-1:0] s_disp_y,
    input  logic signed [COORD_WIDTH-1:0] s_fixed_left,
    input  logic signed [COORD_WIDTH-1:0] s_fixed_top,
    input  logic signed [COORD_WIDTH-1:0] s_fixed_right,
    input  logic signed [COORD_WIDTH-1:0] s_fixed_bottom,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [TIME_FRAC_BITS:0]       m_hit_time,
    output logic signed [1:0]             m_normal_x,
    output logic signed [1:0]             m_normal_y
);

    localparam int unsigned W     = COORD_WIDTH;
    localparam int unsigned F     = TIME_FRAC_BITS;
    localparam int unsigned NSTEP = F + 2;
    localparam int unsigned NS    = NSTEP + 3;

    logic [NS-1:0] v_reg, v_next, en;

    sbct_pkg::sbct_flags_t                          front_flags;
    logic [sbct_pkg::NUM_LANES-1:0][W:0]            front_mag;
    logic [sbct_pkg::NUM_LANES-1:0][W-1:0]          front_den;
    logic [sbct_pkg::NUM_LANES-1:0]                 front_neg, front_ovf;
    logic [sbct_pkg::NUM_LANES-1:0][F+1:0]          div_q;
    logic [sbct_pkg::NUM_LANES-1:0]                 div_remnz, div_neg, div_ovf;
    sbct_pkg::sbct_flags_t                          flags_reg [NSTEP];

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int k = 1; k < NS; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    sbct_front #(.W(W)) u_front (
        .aclk         (aclk),
        .en           (en[0]),
        .move_left    (s_move_left),
        .move_top     (s_move_top),
        .move_right   (s_move_right),
        .move_bottom  (s_move_bottom),
        .disp_x       (s_disp_x),
        .disp_y       (s_disp_y),
        .fixed_left   (s_fixed_left),
        .fixed_top    (s_fixed_top),
        .fixed_right  (s_fixed_right),
        .fixed_bottom (s_fixed_bottom),
        .flags_o      (front_flags),
        .mag_o        (front_mag),
        .den_o        (front_den),
        .neg_o        (front_neg),
        .ovf_o        (front_ovf)
    );

    // Four divider lanes: entry and exit time on each axis.
    for (genvar i = 0; i < sbct_pkg::NUM_LANES; i++) begin : g_lane
        sbct_div #(.W(W), .F(F)) u_div (
            .aclk    (aclk),
            .en      (en[NSTEP:1]),
            .mag_i   (front_mag[i]),
            .den_i   (front_den[i]),
            .neg_i   (front_neg[i]),
            .ovf_i   (front_ovf[i]),
            .q_o     (div_q[i]),
            .remnz_o (div_remnz[i]),
            .neg_o   (div_neg[i]),
            .ovf_o   (div_ovf[i])
        );
    end

    // Item flags ride alongside the divider stages.
    for (genvar s = 0; s < NSTEP; s++) begin : g_flags
        always_ff @(posedge aclk) begin
            if (en[s+1]) begin
                flags_reg[s] <= (s == 0) ? front_flags : flags_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    sbct_resolve #(.F(F)) u_resolve (
        .aclk       (aclk),
        .en_fin     (en[NSTEP+1]),
        .en_out     (en[NS-1]),
        .flags_i    (flags_reg[NSTEP-1]),
        .q_i        (div_q),
        .remnz_i    (div_remnz),
        .neg_i      (div_neg),
        .ovf_i      (div_ovf),
        .hit_o      (m_hit),
        .time_o     (m_hit_time),
        .normal_x_o (m_normal_x),
        .normal_y_o (m_normal_y)
    );

    // A result without a hit carries zero time and no normal.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_hit_time == '0) && (m_normal_x == sbct_pkg::NORM_ZERO)
                               && (m_normal_y == sbct_pkg::NORM_ZERO))
        else $error("miss result carries a time or normal");

    // A hit has exactly one nonzero normal component.
    a_hit_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> ((m_normal_x == sbct_pkg::NORM_ZERO)
                              != (m_normal_y == sbct_pkg::NORM_ZERO)))
        else $error("hit normal is not a single axis");

    // The entry time never exceeds one frame.
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit_time[F] == 1'b0) || (m_hit_time[F-1:0] == '0))
        else $error("hit time above one frame");

    // The pipeline is empty as reset is released.
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule
